@@ hw/rtl/bnlm_pkg.sv @@
// Shared types, constants and weight tables of the Bayer non-local-means denoiser.
// Used by every module of the block; depends on nothing.
package bnlm_pkg;

  localparam int unsigned LINE_DEPTH = 8192;
  localparam int unsigned LINE_AW    = $clog2(LINE_DEPTH);
  localparam int unsigned PIX_BITS   = 12;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned WIN        = 11;
  localparam int unsigned LS_ROWS    = 10;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGMA    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STRENGTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_KW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd5;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [4:0] FAR_LAST  = 5'd17;
  localparam logic [3:0] NEAR_LAST = 4'd9;

  typedef logic [PIX_BITS-1:0] pix_t;
  typedef logic [WIN-1:0][WIN-1:0][PIX_BITS-1:0] win_t;

  localparam pix_t PIX_MAX = pix_t'((1 << PIX_BITS) - 1);

  typedef enum logic {KIND_PASS, KIND_NLM} kind_e;

  typedef struct packed {
    kind_e kind;
    pix_t  value;
  } job_t;

  typedef struct packed {
    logic        enable;
    logic [5:0]  sigma;
    logic [6:0]  strength;
    logic [19:0] inv_kw;
    logic [12:0] width;
    logic [12:0] height;
  } cfg_t;

  function automatic logic [7:0] near_weight(input logic [3:0] idx);
    logic [7:0] w;
    case (idx)
      4'd0: w = 8'd244;
      4'd1: w = 8'd220;
      4'd2: w = 8'd197;
      4'd3: w = 8'd180;
      4'd4: w = 8'd163;
      4'd5: w = 8'd148;
      4'd6: w = 8'd133;
      4'd7: w = 8'd120;
      4'd8: w = 8'd111;
      default: w = 8'd99;
    endcase
    return w;
  endfunction

  function automatic logic [7:0] far_weight(input logic [4:0] idx);
    logic [7:0] w;
    case (idx)
      5'd0:  w = 8'd85;
      5'd1:  w = 8'd70;
      5'd2:  w = 8'd57;
      5'd3:  w = 8'd47;
      5'd4:  w = 8'd39;
      5'd5:  w = 8'd32;
      5'd6:  w = 8'd26;
      5'd7:  w = 8'd21;
      5'd8:  w = 8'd18;
      5'd9:  w = 8'd15;
      5'd10: w = 8'd12;
      5'd11: w = 8'd10;
      5'd12: w = 8'd8;
      5'd13: w = 8'd7;
      5'd14: w = 8'd6;
      5'd15: w = 8'd3;
      5'd16: w = 8'd1;
      default: w = 8'd0;
    endcase
    return w;
  endfunction

endpackage

@@ hw/rtl/bnlm_fifo.sv @@
// Short job queue between the front and the back of the denoiser.
// Depends on bnlm_pkg for the job type and depth.
module bnlm_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bnlm_pkg::job_t  job_i,
  input  logic            pop_i,
  output bnlm_pkg::job_t  job_o,
  output logic            full_o,
  output logic            empty_o
);
  import bnlm_pkg::*;

  job_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr_q, rptr_q;
  logic [FIFO_AW:0]   cnt_q;

  assign full_o  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign job_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == FIFO_AW'(FIFO_DEPTH-1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == FIFO_AW'(FIFO_DEPTH-1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= job_i;
    end
  end

endmodule

@@ hw/rtl/bnlm_front.sv @@
// Front of the denoiser: accepts items, holds the line store and the 11x11 window,
// tracks frame and drain position and queues jobs. Depends on bnlm_pkg.
module bnlm_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bnlm_pkg::cfg_t  cfg_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            operation_i,
  input  bnlm_pkg::pix_t  pixel_in_i,
  output logic            push_o,
  output bnlm_pkg::job_t  push_job_o,
  input  logic            full_i,
  input  logic            done_i,
  output bnlm_pkg::win_t  win_o
);
  import bnlm_pkg::*;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_LS_RD, ST_DR_RD} state_e;

  localparam logic [LINE_AW-1:0] ADDR_LAST  = LINE_AW'(LINE_DEPTH - 1);
  localparam logic [2:0]         DRAIN_WIN  = 3'd5;
  localparam logic [2:0]         DRAIN_ROWS = 3'd5;
  localparam logic [DIM_W-1:0]   EMIT_ROW   = 13'd5;
  localparam logic [DIM_W-1:0]   EMIT_COL   = 13'd4;
  localparam logic [DIM_W-1:0]   EDGE_LAST  = 13'd9;

  state_e             state_q, state_d;
  logic [LINE_AW-1:0] clr_q, clr_d;
  logic [DIM_W-1:0]   row_q, row_d, col_q, col_d;
  logic [LINE_AW-1:0] addr_q, addr_d;
  logic [2:0]         dcnt_q, dcnt_d, drow_q, drow_d;
  logic [DIM_W-1:0]   dcol_q, dcol_d;
  logic [LINE_AW-1:0] daddr_q, daddr_d;
  logic               busy_q, busy_d;
  logic               emit_q, emit_d, active_q, active_d;
  win_t               win_q;
  pix_t               pix_q;

  pix_t               ls_mem [LS_ROWS][LINE_DEPTH];
  pix_t               rd_q [LS_ROWS];
  pix_t               wdata [LS_ROWS];
  logic               mem_we;
  logic [LINE_AW-1:0] waddr, raddr;

  logic [DIM_W-1:0]   w_eff, h_eff, col_inc, row_inc, dcol_inc;
  logic               accept, adv, dadv;
  logic [3:0]         dwin_col, drd_row;

  assign w_eff    = (cfg_i.width == '0) ? 13'd1 : cfg_i.width;
  assign h_eff    = (cfg_i.height == '0) ? 13'd1 : cfg_i.height;
  assign col_inc  = col_q + 13'd1;
  assign row_inc  = row_q + 13'd1;
  assign dcol_inc = dcol_q + 13'd1;
  assign dwin_col = 4'd6 + {1'b0, dcnt_q};
  assign drd_row  = 4'd5 + {1'b0, drow_q};

  assign in_stall_o = !(state_q == ST_IDLE && !full_i && !busy_q);
  assign accept     = in_valid_i && !in_stall_o;
  assign win_o      = win_q;

  assign mem_we = (state_q == ST_CLEAR) || (state_q == ST_LS_RD);
  assign waddr  = (state_q == ST_CLEAR) ? clr_q : addr_q;
  assign raddr  = (operation_i == OP_DRAIN) ? daddr_q : addr_q;

  always_comb begin
    for (int r = 0; r < LS_ROWS; r++) begin
      if (state_q == ST_CLEAR) begin
        wdata[r] = '0;
      end else if (r == LS_ROWS - 1) begin
        wdata[r] = pix_q;
      end else begin
        wdata[r] = rd_q[r+1];
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    row_d      = row_q;
    col_d      = col_q;
    addr_d     = addr_q;
    dcnt_d     = dcnt_q;
    drow_d     = drow_q;
    dcol_d     = dcol_q;
    daddr_d    = daddr_q;
    busy_d     = busy_q;
    emit_d     = emit_q;
    active_d   = active_q;
    push_o     = 1'b0;
    push_job_o = '{kind: KIND_PASS, value: pixel_in_i};
    adv        = 1'b0;
    dadv       = 1'b0;
    if (done_i) begin
      busy_d = 1'b0;
    end
    case (state_q)
      ST_CLEAR: begin
        clr_d = (clr_q == ADDR_LAST) ? '0 : clr_q + 1'b1;
        if (clr_q == ADDR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (operation_i == OP_DRAIN) begin
            if (cfg_i.enable && drow_q != DRAIN_ROWS) begin
              if (dcnt_q < DRAIN_WIN) begin
                push_o           = 1'b1;
                push_job_o.value = win_q[5][dwin_col];
                dcnt_d           = dcnt_q + 3'd1;
              end else begin
                state_d = ST_DR_RD;
              end
            end
          end else begin
            dcnt_d  = '0;
            drow_d  = '0;
            dcol_d  = '0;
            daddr_d = '0;
            if (!cfg_i.enable) begin
              push_o = 1'b1;
              adv    = 1'b1;
            end else begin
              emit_d   = (row_q > EMIT_ROW) || (row_q == EMIT_ROW && col_q > EMIT_COL);
              active_d = (row_q > EDGE_LAST) && (col_q > EDGE_LAST);
              state_d  = ST_LS_RD;
            end
          end
        end
      end
      ST_LS_RD: begin
        if (emit_q) begin
          push_o = 1'b1;
          if (active_q) begin
            push_job_o.kind = KIND_NLM;
            busy_d          = 1'b1;
          end else begin
            push_job_o.value = win_q[5][6];
          end
        end
        adv     = 1'b1;
        state_d = ST_IDLE;
      end
      ST_DR_RD: begin
        push_o           = 1'b1;
        push_job_o.value = rd_q[drd_row];
        dadv             = 1'b1;
        state_d          = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    if (adv) begin
      if (col_inc >= w_eff) begin
        col_d  = '0;
        addr_d = '0;
        row_d  = (row_inc >= h_eff) ? '0 : row_inc;
      end else begin
        col_d  = col_inc;
        addr_d = (addr_q == ADDR_LAST) ? '0 : addr_q + 1'b1;
      end
    end
    if (dadv) begin
      if (dcol_inc >= w_eff) begin
        dcol_d  = '0;
        daddr_d = '0;
        drow_d  = drow_q + 3'd1;
      end else begin
        dcol_d  = dcol_inc;
        daddr_d = (daddr_q == ADDR_LAST) ? '0 : daddr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      row_q    <= '0;
      col_q    <= '0;
      addr_q   <= '0;
      dcnt_q   <= '0;
      drow_q   <= '0;
      dcol_q   <= '0;
      daddr_q  <= '0;
      busy_q   <= 1'b0;
      emit_q   <= 1'b0;
      active_q <= 1'b0;
      win_q    <= '0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      row_q    <= row_d;
      col_q    <= col_d;
      addr_q   <= addr_d;
      dcnt_q   <= dcnt_d;
      drow_q   <= drow_d;
      dcol_q   <= dcol_d;
      daddr_q  <= daddr_d;
      busy_q   <= busy_d;
      emit_q   <= emit_d;
      active_q <= active_d;
      if (state_q == ST_LS_RD) begin
        for (int r = 0; r < WIN; r++) begin
          for (int c = 0; c < WIN - 1; c++) begin
            win_q[r][c] <= win_q[r][c+1];
          end
        end
        for (int r = 0; r < LS_ROWS; r++) begin
          win_q[r][WIN-1] <= rd_q[r];
        end
        win_q[WIN-1][WIN-1] <= pix_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < LS_ROWS; r++) begin
      if (mem_we) begin
        ls_mem[r][waddr] <= wdata[r];
      end
      rd_q[r] <= ls_mem[r][raddr];
    end
    if (accept) begin
      pix_q <= pixel_in_i;
    end
  end

  a_push_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_o && full_i))
    else $error("job pushed into a full queue");

  a_shift_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LS_RD) |-> !busy_q)
    else $error("window shifted while the back still reads it");

  a_busy_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && push_job_o.kind == KIND_NLM) |=> busy_q)
    else $error("denoise job queued without holding the window");

endmodule

@@ hw/rtl/bnlm_back.sv @@
// Back of the denoiser: pops jobs, runs the iterative patch distance, weight and
// divide sequence on the window, and holds the output register. Depends on bnlm_pkg.
module bnlm_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bnlm_pkg::cfg_t  cfg_i,
  output logic            pop_o,
  input  bnlm_pkg::job_t  job_i,
  input  logic            empty_i,
  input  bnlm_pkg::win_t  win_i,
  output logic            done_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output bnlm_pkg::pix_t  pixel_out_o
);
  import bnlm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP0, S_SETUP1, S_DIST, S_W1, S_W2, S_W3, S_W4,
    S_FIN0, S_FIN1, S_DIV, S_DONE
  } state_e;

  state_e      state_q;
  logic        out_valid_q;
  pix_t        out_pix_q, res_q;
  logic [12:0] ks_q, floor2_q;
  logic [17:0] ks2_q;
  logic [2:0]  ky_q, kx_q;
  logic [1:0]  ea_q, eb_q;
  logic        tail_q, sq_vld_q;
  logic [23:0] sq_q;
  logic [27:0] acc_q;
  logic        far_q, lo_q, hi_q, zero_q;
  logic [22:0] m_q;
  logic [42:0] prod_q;
  logic [7:0]  maxw_q;
  logic [12:0] totw_q;
  logic [19:0] wv_q;
  logic [24:0] totv_q;
  logic [12:0] rem_q;
  logic [24:0] quo_q;
  logic [4:0]  dcnt_q;

  logic        can_load, out_load;
  logic [3:0]  rp, cp, rq, cq, rc, cc;
  pix_t        pv, qv, diff, center;
  logic [23:0] sq;
  logic [27:0] pdist;
  logic [30:0] d5;
  logic [31:0] d10;
  logic [20:0] ks6;
  logic [22:0] ks22;
  logic [21:0] ks9;
  logic        far, lo, hi;
  logic [22:0] m, t;
  logic [7:0]  w;
  logic [24:0] totv_sum;
  logic [13:0] trial;
  logic        ge;
  logic [12:0] rem_n;
  logic [24:0] quo_n;
  logic [2:0]  nx, ny;
  logic [11:0] sig_sq;

  assign can_load    = !out_valid_q || !out_stall_i;
  assign pop_o       = (state_q == S_IDLE) && !empty_i && can_load;
  assign done_o      = (state_q == S_DONE) && can_load;
  assign out_load    = (pop_o && job_i.kind == KIND_PASS) || done_o;
  assign out_valid_o = out_valid_q;
  assign pixel_out_o = out_pix_q;

  assign rp     = 4'd4 + {2'b00, ea_q};
  assign cp     = 4'd4 + {2'b00, eb_q};
  assign rq     = {ky_q, 1'b0} + {2'b00, ea_q};
  assign cq     = {kx_q, 1'b0} + {2'b00, eb_q};
  assign rc     = {ky_q, 1'b1};
  assign cc     = {kx_q, 1'b1};
  assign pv     = win_i[rp][cp];
  assign qv     = win_i[rq][cq];
  assign center = win_i[rc][cc];
  assign diff   = (pv > qv) ? pv - qv : qv - pv;
  assign sq     = 24'(diff) * 24'(diff);

  assign pdist = (acc_q < 28'(floor2_q)) ? 28'(floor2_q) : acc_q;
  assign d5    = 31'(pdist) * 31'd5;
  assign d10   = 32'(pdist) * 32'd10;
  assign ks6   = 21'(ks2_q) * 21'd6;
  assign ks22  = 23'(ks2_q) * 23'd22;
  assign ks9   = 22'(ks2_q) * 22'd9;
  assign far   = pdist > 28'(ks2_q);
  assign lo    = far ? (d5 < 31'(ks6)) : (d10 < 32'(ks2_q));
  assign hi    = far ? (d5 >= 31'(ks22)) : (d10 >= 32'(ks9));
  assign m     = far ? d5[22:0] : d10[22:0];
  assign t     = prod_q[42:20];

  assign sig_sq = 12'(cfg_i.sigma) * 12'(cfg_i.sigma);

  always_comb begin
    if (zero_q) begin
      w = 8'd0;
    end else if (far_q) begin
      if (lo_q) begin
        w = far_weight(5'd0);
      end else if (hi_q || t < 23'd5 || t > 23'd22) begin
        w = far_weight(FAR_LAST);
      end else begin
        w = far_weight(5'(t - 23'd5));
      end
    end else begin
      if (lo_q) begin
        w = near_weight(4'd0);
      end else if (hi_q || t > 23'd9) begin
        w = near_weight(NEAR_LAST);
      end else begin
        w = near_weight(4'(t));
      end
    end
  end

  assign totv_sum = totv_q + 25'(wv_q);
  assign trial    = {rem_q, quo_q[24]};
  assign ge       = trial >= {1'b0, totw_q};
  assign rem_n    = ge ? 13'(trial - {1'b0, totw_q}) : trial[12:0];
  assign quo_n    = {quo_q[23:0], ge};

  always_comb begin
    nx = (kx_q == 3'd4) ? 3'd0 : kx_q + 3'd1;
    ny = (kx_q == 3'd4) ? ky_q + 3'd1 : ky_q;
    if (ny == 3'd2 && nx == 3'd2) begin
      nx = 3'd3;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      out_pix_q   <= '0;
      res_q       <= '0;
      ks_q        <= '0;
      floor2_q    <= '0;
      ks2_q       <= '0;
      ky_q        <= '0;
      kx_q        <= '0;
      ea_q        <= '0;
      eb_q        <= '0;
      tail_q      <= 1'b0;
      sq_vld_q    <= 1'b0;
      sq_q        <= '0;
      acc_q       <= '0;
      far_q       <= 1'b0;
      lo_q        <= 1'b0;
      hi_q        <= 1'b0;
      zero_q      <= 1'b0;
      m_q         <= '0;
      prod_q      <= '0;
      maxw_q      <= '0;
      totw_q      <= '0;
      wv_q        <= '0;
      totv_q      <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      dcnt_q      <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (pop_o) begin
            if (job_i.kind == KIND_PASS) begin
              out_pix_q <= job_i.value;
            end else begin
              state_q <= S_SETUP0;
            end
          end
        end
        S_SETUP0: begin
          ks_q     <= 13'(13'(cfg_i.sigma) * 13'(cfg_i.strength));
          floor2_q <= {sig_sq, 1'b0};
          state_q  <= S_SETUP1;
        end
        S_SETUP1: begin
          ks2_q    <= 18'((26'(ks_q) * 26'(ks_q)) >> 8);
          ky_q     <= '0;
          kx_q     <= '0;
          ea_q     <= '0;
          eb_q     <= '0;
          tail_q   <= 1'b0;
          sq_vld_q <= 1'b0;
          acc_q    <= '0;
          maxw_q   <= '0;
          totw_q   <= '0;
          totv_q   <= '0;
          state_q  <= S_DIST;
        end
        S_DIST: begin
          if (sq_vld_q) begin
            acc_q <= acc_q + 28'(sq_q);
          end
          if (tail_q) begin
            tail_q   <= 1'b0;
            sq_vld_q <= 1'b0;
            state_q  <= S_W1;
          end else begin
            sq_q     <= sq;
            sq_vld_q <= 1'b1;
            if (eb_q == 2'd2) begin
              eb_q <= '0;
              if (ea_q == 2'd2) begin
                ea_q   <= '0;
                tail_q <= 1'b1;
              end else begin
                ea_q <= ea_q + 2'd1;
              end
            end else begin
              eb_q <= eb_q + 2'd1;
            end
          end
        end
        S_W1: begin
          far_q   <= far;
          lo_q    <= lo;
          hi_q    <= hi;
          zero_q  <= (ks2_q == '0);
          m_q     <= m;
          state_q <= S_W2;
        end
        S_W2: begin
          prod_q  <= 43'(m_q) * 43'(cfg_i.inv_kw);
          state_q <= S_W3;
        end
        S_W3: begin
          if (w > maxw_q) begin
            maxw_q <= w;
          end
          totw_q  <= totw_q + 13'(w);
          wv_q    <= 20'(w) * 20'(center);
          state_q <= S_W4;
        end
        S_W4: begin
          totv_q <= totv_sum;
          acc_q  <= '0;
          if (ky_q == 3'd4 && kx_q == 3'd4) begin
            state_q <= S_FIN0;
          end else begin
            kx_q    <= nx;
            ky_q    <= ny;
            state_q <= S_DIST;
          end
        end
        S_FIN0: begin
          totw_q  <= totw_q + 13'(maxw_q);
          wv_q    <= 20'(maxw_q) * 20'(win_i[5][5]);
          state_q <= S_FIN1;
        end
        S_FIN1: begin
          totv_q <= totv_sum;
          if (totw_q == '0) begin
            res_q   <= win_i[5][5];
            state_q <= S_DONE;
          end else begin
            rem_q   <= '0;
            quo_q   <= totv_sum;
            dcnt_q  <= 5'd24;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          rem_q <= rem_n;
          quo_q <= quo_n;
          if (dcnt_q == '0) begin
            res_q   <= (quo_n > 25'(PIX_MAX)) ? PIX_MAX : quo_n[PIX_BITS-1:0];
            state_q <= S_DONE;
          end else begin
            dcnt_q <= dcnt_q - 5'd1;
          end
        end
        S_DONE: begin
          if (can_load) begin
            out_pix_q <= res_q;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (totw_q != '0))
    else $error("divide started with zero total weight");

  a_tail_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIST && tail_q) |-> sq_vld_q)
    else $error("patch distance closed without its last term");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_o && empty_i))
    else $error("job popped from an empty queue");

endmodule

@@ hw/rtl/bayer_nonlocal_means_denoise_core.sv @@
// Top level of the Bayer raw non-local-means denoiser: configuration registers,
// front, job queue and back. Depends on bnlm_pkg, bnlm_front, bnlm_fifo, bnlm_back.
//
// Use: raw pixels enter on the input channel (operation_i, pixel_in_i) in raster
// order; results leave on the output channel as pixel_out_o. An item is taken when
// valid is high and stall is low. Registers are written on the configuration
// channel (cfg_index_i, cfg_data_i), which is always ready; write them while idle.
// Disabled pixels and the first five drains of a run need no line store read;
// later drains and enabled pixels first read the line store, then output or
// shift the window and write back. A pixel inside the border, once its centre
// is valid, is denoised by the back: 24 neighbours, each through the
// one-difference-per-cycle patch distance and the weight multiply, then a
// restoring divider; the input stalls until it is done. Other results pass
// through the job queue and the output register.
// A four-entry job queue and the output register let the front take items while
// a result waits; a stalled output holds its value and fills the queue, after
// which the input stalls. After reset the line store is cleared, one address per
// cycle over all 8192 addresses, during which the input stalls.
module bayer_nonlocal_means_denoise_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [bnlm_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [bnlm_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  operation_i,
  input  logic [bnlm_pkg::PIX_BITS-1:0]         pixel_in_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [bnlm_pkg::PIX_BITS-1:0]         pixel_out_o
);
  import bnlm_pkg::*;

  cfg_t cfg_q;
  logic push, pop, full, empty, done;
  job_t push_job, pop_job;
  win_t win;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable   <= 1'b0;
      cfg_q.sigma    <= '0;
      cfg_q.strength <= '0;
      cfg_q.inv_kw   <= '0;
      cfg_q.width    <= 13'd1;
      cfg_q.height   <= 13'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ENABLE:   cfg_q.enable   <= cfg_data_i[0];
        CFG_SIGMA:    cfg_q.sigma    <= cfg_data_i[5:0];
        CFG_STRENGTH: cfg_q.strength <= cfg_data_i[6:0];
        CFG_INV_KW:   cfg_q.inv_kw   <= cfg_data_i[19:0];
        CFG_WIDTH:    cfg_q.width    <= cfg_data_i[12:0];
        CFG_HEIGHT:   cfg_q.height   <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  bnlm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .pixel_in_i  (pixel_in_i),
    .push_o      (push),
    .push_job_o  (push_job),
    .full_i      (full),
    .done_i      (done),
    .win_o       (win)
  );

  bnlm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (pop_job),
    .full_o  (full),
    .empty_o (empty)
  );

  bnlm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_o       (pop),
    .job_i       (pop_job),
    .empty_i     (empty),
    .win_i       (win),
    .done_o      (done),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pixel_out_o (pixel_out_o)
  );

endmodule
